// ===== rtl/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants for the chamfer distance transform
// Request codes, config indices, step weights, sequencer states and default grid limits.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int unsigned MAX_ROWS_DEF = 256;
  localparam int unsigned MAX_COLS_DEF = 256;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_MARK  = 2'd1;
  localparam logic [1:0] REQ_XFORM = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_INF  = 2'd2;

  localparam logic [2:0] STEP_D3 = 3'd3;
  localparam logic [2:0] STEP_D4 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for a beat
    ST_FILL,   // clear sweep, one cell a cycle
    ST_CRD,    // read centre cell
    ST_CWAIT,  // centre data returns
    ST_NRD,    // read neighbour k
    ST_NWAIT,  // neighbour data returns, compare
    ST_WB,     // write back centre
    ST_QRD,    // query read
    ST_QWAIT,  // query data returns
    ST_OUT     // result held for the master side
  } state_t;

endpackage

// ===== rtl/cdt_ram.sv =====
// ----------------------------------------------------------------------------
// cdt_ram: generic single-port RAM
// One access per cycle (a write also reads the old word); read data registered.
// ----------------------------------------------------------------------------
module cdt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/chamfer_distance_transform.sv =====
// ----------------------------------------------------------------------------
// chamfer_distance_transform: 3-4 chamfer clearance engine for an occupancy grid
// Distance and nearest-obstacle stores in RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Beat in to result beat: mark and out-of-map query answer in the cycle after
//   the beat, in-map query after a read and a wait state, clear after a sweep
//   of every cell. Transform: a centre read, four neighbour reads and a write
//   back per cell per pass; a cell at distance 0 skips the neighbour reads.
// One beat in flight at a time; s_tready is low while a beat is being worked.
// Reset: a clearing pass over every cell fills the stores with 65535 /
//   (-1,-1), then idle; no beat is taken meanwhile, config is.
// ----------------------------------------------------------------------------
module chamfer_distance_transform #(
  parameter int unsigned MAX_ROWS = cdt_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = cdt_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] cell_row, [31:16] cell_col
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] clear_dist, [24:16] near_row,
                                 // [33:25] near_col, [34] in_map, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned AW    = RW + CW;
  // store depth: cell (r,c) sits at {r,c}, so the depth is a power of two
  localparam int unsigned CELLS = 1 << AW;
  // nearest stored as {row(RW+1 signed), col(CW+1 signed)}
  localparam int unsigned PW    = RW + CW + 2;

  // ---- configuration registers
  logic [8:0]  map_rows, map_cols;
  logic [15:0] inf_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows     <= 9'd256;
      map_cols     <= 9'd256;
      inf_distance <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cdt_pkg::CFG_ROWS: map_rows     <= cfg_data[8:0];
        cdt_pkg::CFG_COLS: map_cols     <= cfg_data[8:0];
        cdt_pkg::CFG_INF:  inf_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective size: min(map, MAX)
  logic [10:0] rows_u, cols_u;
  assign rows_u = (11'(map_rows) < 11'(MAX_ROWS)) ? 11'(map_rows) : 11'(MAX_ROWS);
  assign cols_u = (11'(map_cols) < 11'(MAX_COLS)) ? 11'(map_cols) : 11'(MAX_COLS);

  // ---- stores
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [15:0]     dwr, drd;
  logic [PW-1:0]   nwr, nrd;

  cdt_ram #(.WIDTH(16), .DEPTH(CELLS)) u_dist (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(dwr), .rdata(drd));
  cdt_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_near (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(nwr), .rdata(nrd));

  // ---- sequencer registers
  cdt_pkg::state_t state, state_next;
  logic [AW:0]     fill_cnt;          // sweep counter, one bit wider than the address
  logic [15:0]     fill_val;
  logic            boot;              // sweep after reset, no result beat
  logic            pass_bwd;          // 0 forward, 1 backward
  logic [10:0]     ci, cj;            // centre cell
  logic [1:0]      nk;                // neighbour number
  logic [15:0]     cur_d;
  logic [PW-1:0]   cur_n;
  logic            cur_dirty;
  logic [AW-1:0]   q_addr;            // query cell
  logic [15:0]     res_dist;
  logic [8:0]      res_row, res_col;
  logic            res_in;

  // input decode
  logic signed [15:0] in_r, in_c;
  logic               in_map_hit;
  assign in_r   = s_tdata[15:0];
  assign in_c   = s_tdata[31:16];
  assign in_map_hit = !in_r[15] && !in_c[15] &&
                      (17'(in_r) < 17'(rows_u)) && (17'(in_c) < 17'(cols_u));

  logic [AW-1:0] in_addr;
  assign in_addr = {in_r[RW-1:0], in_c[CW-1:0]};

  // neighbour offsets: forward left, up-right, up, up-left; backward mirrored
  logic [10:0] nbi, nbj;
  logic [2:0]  nstep;
  always_comb begin
    nbi   = ci;
    nbj   = cj;
    nstep = cdt_pkg::STEP_D3;
    unique case (nk)
      2'd0: begin nbj = pass_bwd ? cj + 11'd1 : cj - 11'd1; nstep = cdt_pkg::STEP_D3; end
      2'd1: begin
        nbi = pass_bwd ? ci + 11'd1 : ci - 11'd1;
        nbj = pass_bwd ? cj - 11'd1 : cj + 11'd1;
        nstep = cdt_pkg::STEP_D4;
      end
      2'd2: begin nbi = pass_bwd ? ci + 11'd1 : ci - 11'd1; nstep = cdt_pkg::STEP_D3; end
      default: begin
        nbi = pass_bwd ? ci + 11'd1 : ci - 11'd1;
        nbj = pass_bwd ? cj + 11'd1 : cj - 11'd1;
        nstep = cdt_pkg::STEP_D4;
      end
    endcase
  end

  // shared compare unit
  logic [16:0] cand;
  logic        better;
  assign cand   = 17'(drd) + 17'(nstep);
  assign better = cand < 17'(cur_d);

  // walk control
  logic fwd_ok, bwd_ok;
  assign fwd_ok = (rows_u >= 11'd2) && (cols_u >= 11'd3);
  assign bwd_ok = (rows_u >= 11'd3) && (cols_u >= 11'd3);
  logic       last_col, last_row;
  assign last_col = pass_bwd ? (cj == 11'd1) : (cj == cols_u - 11'd2);
  assign last_row = pass_bwd ? (ci == 11'd1) : (ci == rows_u - 11'd1);

  logic fill_done;
  assign fill_done = (fill_cnt == (AW+1)'(CELLS - 1));

  logic [PW-1:0] none_pair;
  assign none_pair = '1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cdt_pkg::ST_IDLE:
        if (s_tvalid) begin
          unique case (s_tuser)
            cdt_pkg::REQ_CLEAR: state_next = cdt_pkg::ST_FILL;
            cdt_pkg::REQ_MARK:  state_next = cdt_pkg::ST_OUT;
            cdt_pkg::REQ_XFORM: state_next = fwd_ok ? cdt_pkg::ST_CRD : cdt_pkg::ST_OUT;
            default:            state_next = in_map_hit ? cdt_pkg::ST_QRD : cdt_pkg::ST_OUT;
          endcase
        end
      cdt_pkg::ST_FILL:  if (fill_done) state_next = boot ? cdt_pkg::ST_IDLE : cdt_pkg::ST_OUT;
      cdt_pkg::ST_CRD:   state_next = cdt_pkg::ST_CWAIT;
      cdt_pkg::ST_CWAIT: state_next = (drd == 16'd0) ? cdt_pkg::ST_WB : cdt_pkg::ST_NRD;
      cdt_pkg::ST_NRD:   state_next = cdt_pkg::ST_NWAIT;
      cdt_pkg::ST_NWAIT: state_next = (nk == 2'd3) ? cdt_pkg::ST_WB : cdt_pkg::ST_NRD;
      cdt_pkg::ST_WB:
        if (last_col && last_row) begin
          state_next = (!pass_bwd && bwd_ok) ? cdt_pkg::ST_CRD : cdt_pkg::ST_OUT;
        end else begin
          state_next = cdt_pkg::ST_CRD;
        end
      cdt_pkg::ST_QRD:   state_next = cdt_pkg::ST_QWAIT;
      cdt_pkg::ST_QWAIT: state_next = cdt_pkg::ST_OUT;
      cdt_pkg::ST_OUT:   if (m_tready) state_next = cdt_pkg::ST_IDLE;
      default:           state_next = cdt_pkg::ST_IDLE;
    endcase
  end

  // RAM port and handshake outputs
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    dwr      = cur_d;
    nwr      = cur_n;
    unique case (state)
      cdt_pkg::ST_IDLE: begin
        ram_addr = in_addr;
        dwr      = 16'd0;
        nwr      = {1'b0, in_r[RW-1:0], 1'b0, in_c[CW-1:0]};
        ram_we   = s_tvalid && (s_tuser == cdt_pkg::REQ_MARK) && in_map_hit;
      end
      cdt_pkg::ST_FILL: begin
        ram_we   = 1'b1;
        ram_addr = fill_cnt[AW-1:0];
        dwr      = fill_val;
        nwr      = none_pair;
      end
      cdt_pkg::ST_CRD:  ram_addr = {ci[RW-1:0], cj[CW-1:0]};
      cdt_pkg::ST_NRD:  ram_addr = {nbi[RW-1:0], nbj[CW-1:0]};
      cdt_pkg::ST_WB: begin
        ram_addr = {ci[RW-1:0], cj[CW-1:0]};
        ram_we   = cur_dirty;
      end
      cdt_pkg::ST_QRD:  ram_addr = q_addr;
      default: ;
    endcase
  end

  assign s_tready = (state == cdt_pkg::ST_IDLE);
  assign m_tvalid = (state == cdt_pkg::ST_OUT);
  assign m_tdata  = {5'd0, res_in, res_col, res_row, res_dist};

  // nearest pair to 9-bit outputs (sign extend / wrap)
  function automatic logic [8:0] to9(input logic [RW:0] v);
    logic [31:0] e;
    e = {{(31-RW){v[RW]}}, v};
    return e[8:0];
  endfunction
  function automatic logic [8:0] to9c(input logic [CW:0] v);
    logic [31:0] e;
    e = {{(31-CW){v[CW]}}, v};
    return e[8:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cdt_pkg::ST_FILL;
      fill_cnt <= '0;
      fill_val <= 16'hFFFF;
      boot     <= 1'b1;
      res_in   <= 1'b0;
      pass_bwd <= 1'b0;
      nk       <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        cdt_pkg::ST_IDLE:
          if (s_tvalid) begin
            res_dist <= 16'd0;
            res_row  <= 9'h1FF;
            res_col  <= 9'h1FF;
            res_in   <= 1'b0;
            fill_cnt <= '0;
            fill_val <= inf_distance;
            pass_bwd <= 1'b0;
            ci       <= 11'd1;
            cj       <= 11'd1;
            q_addr   <= in_addr;
            if (s_tuser == cdt_pkg::REQ_MARK) res_in <= in_map_hit;
            if (s_tuser == cdt_pkg::REQ_QUERY) begin
              res_in <= in_map_hit;
              if (!in_map_hit) res_dist <= inf_distance;
            end
          end
        cdt_pkg::ST_FILL: begin
          fill_cnt <= fill_cnt + (AW+1)'(1);
          if (fill_done) boot <= 1'b0;
        end
        cdt_pkg::ST_CWAIT: begin
          cur_d     <= drd;
          cur_n     <= nrd;
          cur_dirty <= 1'b0;
          nk        <= '0;
        end
        cdt_pkg::ST_NWAIT: begin
          if (better) begin
            cur_d     <= cand[15:0];
            cur_n     <= nrd;
            cur_dirty <= 1'b1;
          end
          nk <= nk + 2'd1;
        end
        cdt_pkg::ST_WB: begin
          if (last_col) begin
            if (last_row) begin
              pass_bwd <= 1'b1;
              ci       <= rows_u - 11'd2;
              cj       <= cols_u - 11'd2;
            end else begin
              ci <= pass_bwd ? ci - 11'd1 : ci + 11'd1;
              cj <= pass_bwd ? cols_u - 11'd2 : 11'd1;
            end
          end else begin
            cj <= pass_bwd ? cj - 11'd1 : cj + 11'd1;
          end
        end
        cdt_pkg::ST_QWAIT: begin
          res_dist <= drd;
          res_row  <= to9(nrd[PW-1 -: RW+1]);
          res_col  <= to9c(nrd[CW:0]);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for chamfer_distance_transform
// Drives clear/mark/transform/query beats on the slave side. A scoreboard
// keeps its own copy of the grid and the registers, predicts every result
// beat and compares it field by field. Sender gaps and receiver stalls are
// applied in phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GRID      = 256;
  localparam int CELL_CNT  = GRID * GRID;
  localparam int CYC_LIMIT = 8000000;  // clears sweep all 64k cells; a few dozen fit easily
  localparam int SETTLE    = 16;       // query latency with plenty of margin

  // grid predictor and store of expected result beats
  class chamfer_scoreboard;
    logic [15:0] dist_mem[CELL_CNT];
    logic [8:0]  nrow[CELL_CNT];
    logic [8:0]  ncol[CELL_CNT];
    int          rows, cols;
    logic [15:0] inf;
    logic [39:0] expected_q[$];
    int          mismatches;

    function new();
      rows = GRID;
      cols = GRID;
      inf = 16'hffff;
      mismatches = 0;
      wipe(inf);
    endfunction

    function void wipe(logic [15:0] d);
      for (int i = 0; i < CELL_CNT; i++) begin
        dist_mem[i] = d;
        nrow[i] = 9'h1ff;
        ncol[i] = 9'h1ff;
      end
    endfunction

    function int used_rows();
      return (rows < GRID) ? rows : GRID;
    endfunction

    function int used_cols();
      return (cols < GRID) ? cols : GRID;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        cdt_pkg::CFG_ROWS: rows = val[8:0];
        cdt_pkg::CFG_COLS: cols = val[8:0];
        cdt_pkg::CFG_INF:  inf = val;
        default: ;
      endcase
    endfunction

    // one neighbour step; full-width compare, strict less-than
    function void relax(int cur, int nb, int step);
      logic [16:0] cand;
      cand = {1'b0, dist_mem[nb]} + 17'(step);
      if (cand < {1'b0, dist_mem[cur]}) begin
        dist_mem[cur] = cand[15:0];
        nrow[cur] = nrow[nb];
        ncol[cur] = ncol[nb];
      end
    endfunction

    function void sweep();
      int r, c, cur;
      r = used_rows();
      c = used_cols();
      for (int i = 1; i < r; i++)
        for (int j = 1; j < c - 1; j++) begin
          cur = i * GRID + j;
          if (dist_mem[cur] != 0) begin
            relax(cur, cur - 1, 3);
            relax(cur, cur - GRID + 1, 4);
            relax(cur, cur - GRID, 3);
            relax(cur, cur - GRID - 1, 4);
          end
        end
      for (int i = r - 2; i > 0; i--)
        for (int j = c - 2; j > 0; j--) begin
          cur = i * GRID + j;
          if (dist_mem[cur] != 0) begin
            relax(cur, cur + 1, 3);
            relax(cur, cur + GRID - 1, 4);
            relax(cur, cur + GRID, 3);
            relax(cur, cur + GRID + 1, 4);
          end
        end
    endfunction

    function void note_request(logic [1:0] req, logic signed [15:0] row,
                               logic signed [15:0] col);
      bit          hit;
      int          idx;
      logic [15:0] d;
      logic [8:0]  nr, nc;
      logic        inm;
      hit = row >= 0 && row < used_rows() && col >= 0 && col < used_cols();
      idx = hit ? int'(row) * GRID + int'(col) : 0;
      d = '0;
      nr = 9'h1ff;
      nc = 9'h1ff;
      inm = 1'b0;
      case (req)
        cdt_pkg::REQ_CLEAR: wipe(inf);
        cdt_pkg::REQ_MARK: if (hit) begin
          dist_mem[idx] = '0;
          nrow[idx] = row[8:0];
          ncol[idx] = col[8:0];
          inm = 1'b1;
        end
        cdt_pkg::REQ_XFORM: sweep();
        default: if (hit) begin
          d = dist_mem[idx];
          nr = nrow[idx];
          nc = ncol[idx];
          inm = 1'b1;
        end else begin
          d = inf;
        end
      endcase
      expected_q.insert(expected_q.size(), {5'b0, inm, nc, nr, d});
    endfunction

    function void check_result(logic [39:0] got);
      logic [39:0] want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (got[15:0] !== want[15:0] || got[24:16] !== want[24:16] ||
          got[33:25] !== want[33:25] || got[34] !== want[34] ||
          got[39:35] !== want[39:35]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: dist %0d/%0d row %0d/%0d col %0d/%0d in_map %b/%b (exp/got)",
                   want[15:0], got[15:0], $signed(want[24:16]), $signed(got[24:16]),
                   $signed(want[33:25]), $signed(got[33:25]), want[34], got[34]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] cell_row, [31:16] cell_col
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [15:0] clear_dist, [24:16] near_row, [33:25] near_col, [34] in_map
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  chamfer_distance_transform dut (.*);

  chamfer_scoreboard grid_sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_cnt = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit: clearing passes dominate, so be generous
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls at the current phase's rate
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result beats, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) grid_sb.check_result(m_tdata);
  end

  task automatic send_beat(logic [1:0] req, logic signed [15:0] row,
                           logic signed [15:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {col, row};
    do @(posedge clk); while (!s_tready);
    grid_sb.note_request(req, row, col);
    @(negedge clk);
  endtask

  // wait for every expected beat, then let the sequencer settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (grid_sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    grid_sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_map(int rows, int cols, logic [15:0] inf);
    write_reg(cdt_pkg::CFG_ROWS, 16'(rows));
    write_reg(cdt_pkg::CFG_COLS, 16'(cols));
    write_reg(cdt_pkg::CFG_INF, inf);
    cfg_valid <= 1'b0;
  endtask

  // coordinate mostly near the map, sometimes anywhere in 16 bits
  function automatic logic signed [15:0] pick_coord(int lim);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) return (lim > 0) ? 16'(lim) : 16'sd0;
    if (sel == 2) return -16'sd1;
    return (lim > 0) ? 16'($urandom_range(lim - 1)) : 16'sd0;
  endfunction

  task automatic random_phase(int beats, int rows, int cols, logic [15:0] inf);
    int sel;
    bit can_sweep;
    set_map(rows, cols, inf);
    can_sweep = rows <= 20 && cols <= 20;
    if ($urandom_range(1)) send_beat(cdt_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom));
    for (int n = 0; n < beats; n++) begin
      sel = $urandom_range(99);
      if (n == beats / 2 && $urandom_range(1)) begin
        // hold off until the pipe is empty
        drain();
        @(negedge clk);
      end
      if (sel < 38)
        send_beat(cdt_pkg::REQ_MARK, pick_coord(rows), pick_coord(cols));
      else if (sel < 48 && can_sweep)
        send_beat(cdt_pkg::REQ_XFORM, 16'($urandom), 16'($urandom));
      else
        send_beat(cdt_pkg::REQ_QUERY, pick_coord(rows), pick_coord(cols));
    end
    drain();
  endtask

  initial begin
    int rows, cols;
    logic [15:0] inf;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset contents, then a small map
    send_beat(cdt_pkg::REQ_QUERY, 16'sd0, 16'sd0);
    send_beat(cdt_pkg::REQ_QUERY, -16'sd32768, 16'sd32767);
    drain();
    set_map(8, 10, 16'd1000);
    send_beat(cdt_pkg::REQ_MARK, 16'sd0, 16'sd0);
    send_beat(cdt_pkg::REQ_MARK, 16'sd7, 16'sd9);
    send_beat(cdt_pkg::REQ_MARK, 16'sd3, 16'sd4);
    send_beat(cdt_pkg::REQ_MARK, 16'sd8, 16'sd0);      // row just outside
    send_beat(cdt_pkg::REQ_MARK, -16'sd1, 16'sd5);
    send_beat(cdt_pkg::REQ_MARK, 16'sd32767, -16'sd32768);
    send_beat(cdt_pkg::REQ_XFORM, 16'sd0, 16'sd0);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd5, 16'sd6);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd1, 16'sd1);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd7, 16'sd9);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd2, 16'sd10);    // column just outside
    send_beat(cdt_pkg::REQ_CLEAR, 16'sd0, 16'sd0);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd3, 16'sd4);
    drain();
    // degenerate maps: transform with no pass, nothing inside
    set_map(1, 5, 16'd1);
    send_beat(cdt_pkg::REQ_XFORM, 16'sd0, 16'sd0);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd0, 16'sd2);
    drain();
    set_map(0, 0, 16'd65535);
    send_beat(cdt_pkg::REQ_MARK, 16'sd0, 16'sd0);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd0, 16'sd0);
    drain();
    // full-size map, corner cell
    set_map(256, 256, 16'd65535);
    send_beat(cdt_pkg::REQ_MARK, 16'sd255, 16'sd255);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd255, 16'sd255);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd256, 16'sd0);
    drain();
    // zero infinity: cleared cells behave as obstacles
    set_map(6, 6, 16'd0);
    send_beat(cdt_pkg::REQ_CLEAR, 16'sd0, 16'sd0);
    send_beat(cdt_pkg::REQ_XFORM, 16'sd0, 16'sd0);
    send_beat(cdt_pkg::REQ_QUERY, 16'sd2, 16'sd3);
    drain();

    // random phases across idling modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      rows = $urandom_range(2, 16);
      cols = $urandom_range(2, 16);
      if (ph == 3) begin rows = 256; cols = 256; end
      if (ph == 6) begin rows = 3; cols = 3; end
      inf = 16'($urandom_range(1, 65535));
      if (ph == 2) inf = 16'd1;
      if (ph == 5) inf = 16'd65535;
      random_phase(178, rows, cols, inf);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (SETTLE) @(negedge clk);
    if (grid_sb.mismatches == 0 && grid_sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cdt_pkg.sv
rtl/cdt_ram.sv
rtl/chamfer_distance_transform.sv
tb/testbench.sv
